// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types, codes and fixed-point constants of the motor speed ramp and
// position stepper.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int REG_WIDTH       = VALUE_WIDTH - 1;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int OP_WIDTH        = 2;
    localparam int KIND_WIDTH      = 2;
    localparam int SAT_WIDTH       = VALUE_WIDTH + 6;
    localparam int RPM_WIDTH       = VALUE_WIDTH + 4;
    localparam int REM_WIDTH       = VALUE_WIDTH + 5;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [VALUE_WIDTH-1:0] mag_t;
    typedef logic        [REG_WIDTH-1:0]   cfg_t;
    typedef logic signed [SAT_WIDTH-1:0]   wide_t;
    typedef logic signed [RPM_WIDTH-1:0]   rpm_t;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_TICK,
        OP_SET_SPEED,
        OP_MOVE_ABS,
        OP_MOVE_REL
    } op_t;

    typedef enum logic [KIND_WIDTH-1:0] {
        DRIVE_NONE,
        DRIVE_ANGLE,
        DRIVE_VELOCITY
    } drive_t;

    typedef enum logic [1:0] {
        MOTION_ABS,
        MOTION_REL,
        MOTION_SPD
    } mode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SPEED_STEP,
        REG_SPEED_LIMIT,
        REG_ANGLE_STEP
    } reg_index_t;

    // register defaults in whole units
    localparam int DEFAULT_SPEED_STEP  = 1;
    localparam int DEFAULT_SPEED_LIMIT = 120;
    localparam int DEFAULT_ANGLE_STEP  = 18;

    localparam cfg_t SPEED_STEP_RESET  = cfg_t'(longint'(DEFAULT_SPEED_STEP) << FRAC_BITS);
    localparam cfg_t SPEED_LIMIT_RESET = cfg_t'(longint'(DEFAULT_SPEED_LIMIT) << FRAC_BITS);
    localparam cfg_t ANGLE_STEP_RESET  = cfg_t'(longint'(DEFAULT_ANGLE_STEP) << FRAC_BITS);

    // pi and pi + 0.0001 in Q32, rounded to nearest at FRAC_BITS
    localparam longint PI_Q32     = 64'sd13493037705;
    localparam longint PI_EPS_Q32 = 64'sd13493467201;
    localparam longint PI_Q       =
        (PI_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam longint PI_EPS_Q   =
        (PI_EPS_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam longint MIN_RPM    = ((longint'(1) << FRAC_BITS) + 5) / 10;

    // x9.55 = x9 + x11/20, /9.55 = x20/191
    localparam int RPM_INT        = 9;
    localparam int RPM_FRAC_NUM   = 11;
    localparam int RPM_FRAC_DEN   = 20;
    localparam int SPEED_DIV_NUM  = 20;
    localparam int SPEED_DIV_DEN  = 191;

    localparam int LUT_INDEX_WIDTH = $clog2(RPM_FRAC_DEN);
    localparam int LUT_VALUE_WIDTH = 4;

    // floor(11 * b / 20) for a remainder b of a division by 20
    localparam logic [LUT_VALUE_WIDTH-1:0] RPM_FRAC_LUT [RPM_FRAC_DEN] = '{
        4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10
    };

    // pi magnitudes, and reciprocals scaled by 2^VALUE_WIDTH, rounded down
    localparam mag_t PI_MAG         = mag_t'(PI_Q);
    localparam mag_t PI_EPS_MAG     = mag_t'(PI_EPS_Q);
    localparam mag_t RECIP_PI       = mag_t'((longint'(1) << VALUE_WIDTH) / PI_Q);
    localparam mag_t RECIP_PI_EPS   = mag_t'((longint'(1) << VALUE_WIDTH) / PI_EPS_Q);
    localparam mag_t RECIP_FRAC_DEN = mag_t'((longint'(1) << VALUE_WIDTH) / RPM_FRAC_DEN);
    localparam mag_t RECIP_SPEED    =
        mag_t'(((longint'(1) << VALUE_WIDTH) * SPEED_DIV_NUM) / SPEED_DIV_DEN);

    localparam wide_t WIDE_MAX  = wide_t'((longint'(1) << (VALUE_WIDTH - 1)) - 1);
    localparam wide_t WIDE_MIN  = -WIDE_MAX - wide_t'(1);
    localparam wide_t MIN_RPM_W = wide_t'(MIN_RPM);

    function automatic value_t sat_value(input wide_t v);
        value_t r;
        if (v > WIDE_MAX)
        begin
            r = value_t'(WIDE_MAX);
        end
        else if (v < WIDE_MIN)
        begin
            r = value_t'(WIDE_MIN);
        end
        else
        begin
            r = value_t'(v);
        end
        return r;
    endfunction

    function automatic wide_t widen(input value_t v);
        return wide_t'(v);
    endfunction

    function automatic wide_t widen_cfg(input cfg_t c);
        return wide_t'(c);
    endfunction

    function automatic mag_t abs_value(input value_t v);
        return v[VALUE_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic wide_t abs_wide(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

// ===== rtl/msr_item_if.sv =====
// ----------------------------------------------------------------------------
// msr_item_if
// Input channel: one command or tick transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
interface msr_item_if;
    import msr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_WIDTH-1:0] operation;
    value_t              command_value;
    value_t              measured_angle;
    value_t              measured_velocity;

    modport source (
        output valid,
        output operation,
        output command_value,
        output measured_angle,
        output measured_velocity,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  command_value,
        input  measured_angle,
        input  measured_velocity,
        output ready
    );
endinterface

// ===== rtl/msr_result_if.sv =====
// ----------------------------------------------------------------------------
// msr_result_if
// Result channel: one drive command per valid/ready handshake.
// ----------------------------------------------------------------------------
interface msr_result_if;
    import msr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_WIDTH-1:0] drive_kind;
    value_t                drive_value;

    modport source (
        output valid,
        output drive_kind,
        output drive_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive_kind,
        input  drive_value,
        output ready
    );
endinterface

// ===== rtl/motor_speed_ramp_and_position_stepper.sv =====
// ----------------------------------------------------------------------------
// motor_speed_ramp_and_position_stepper
// Rate-limited speed ramp and stepped position mover in signed fixed point.
// ----------------------------------------------------------------------------
// registers in order: input, product, remainder, state update, quotient, output
// throughput: one item per cycle unless result.ready stalls; a six-stage
//   pipeline isolates the reciprocal multipliers from the state update stage
// each stage takes a new item whenever it is empty or its content moves on
// reset: pipeline empty, mode absolute, targets and delta zero, step and
//   limit registers at their defaults; no clearing pass
module motor_speed_ramp_and_position_stepper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [msr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  msr_pkg::cfg_t                        cfg_data,
    msr_item_if.sink                             item,
    msr_result_if.source                         result
);
    import msr_pkg::*;

    localparam int STAGES = 6;
    localparam int W      = VALUE_WIDTH;

    localparam logic [RPM_WIDTH-1:0] RPM_INT_C      = RPM_WIDTH'(RPM_INT);
    localparam logic [RPM_WIDTH-1:0] RPM_FRAC_NUM_C = RPM_WIDTH'(RPM_FRAC_NUM);
    localparam mag_t                 FRAC_DEN_C     = mag_t'(RPM_FRAC_DEN);
    localparam logic [REM_WIDTH-1:0] DIV_NUM_C      = REM_WIDTH'(SPEED_DIV_NUM);
    localparam logic [REM_WIDTH-1:0] DIV_DEN_C      = REM_WIDTH'(SPEED_DIV_DEN);

    // pipeline control
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_feed;
    logic [STAGES:0]   stage_ready;

    // configuration and state
    cfg_t   speed_step_reg;
    cfg_t   speed_limit_reg;
    cfg_t   angle_step_reg;
    mode_t  mode_reg;
    mode_t  mode_next;
    value_t target_speed_reg;
    value_t target_speed_next;
    value_t remaining_delta_reg;
    value_t remaining_delta_next;
    value_t target_angle_reg;
    value_t target_angle_next;
    logic   state_update;

    // stage 0: input register
    op_t    s0_op_reg;
    value_t s0_cmd_reg;
    value_t s0_ang_reg;
    value_t s0_vel_reg;

    // stage 1: reciprocal products
    mag_t               s1_ang_mag_next;
    mag_t               s1_vel_mag_next;
    logic [2*W-1:0]     s1_prod_pi;
    logic [2*W-1:0]     s1_prod_eps;
    logic [2*W-1:0]     s1_prod_vel;
    op_t                s1_op_reg;
    value_t             s1_cmd_reg;
    value_t             s1_ang_reg;
    logic               s1_vel_neg_reg;
    mag_t               s1_ang_mag_reg;
    mag_t               s1_vel_mag_reg;
    mag_t               s1_qpi_reg;
    mag_t               s1_qeps_reg;
    mag_t               s1_qvel_reg;

    // stage 2: remainders and rpm
    mag_t                       s2_rpi_raw;
    mag_t                       s2_rpi;
    mag_t                       s2_reps_raw;
    mag_t                       s2_reps;
    mag_t                       s2_rvel_raw;
    mag_t                       s2_rvel;
    mag_t                       s2_qvel;
    logic [LUT_INDEX_WIDTH-1:0] s2_lut_index;
    logic [RPM_WIDTH-1:0]       s2_rpm_mag;
    value_t                     s2_mod_pi_next;
    value_t                     s2_mod_eps_next;
    rpm_t                       s2_rpm_next;
    op_t                        s2_op_reg;
    value_t                     s2_cmd_reg;
    value_t                     s2_ang_reg;
    value_t                     s2_mod_pi_reg;
    value_t                     s2_mod_eps_reg;
    rpm_t                       s2_rpm_reg;

    // stage 3: state update and step decision
    wide_t  cmd_w;
    wide_t  limit_w;
    wide_t  rpm_w;
    wide_t  ts_w;
    wide_t  sstep_w;
    wide_t  astep_w;
    wide_t  pos_w;
    wide_t  rem_w;
    value_t pos;
    drive_t s3_kind_next;
    value_t s3_value_next;
    value_t s3_speed_next;
    drive_t s3_kind_reg;
    value_t s3_value_reg;
    value_t s3_speed_reg;

    // stage 4: speed back to rad/s, quotient estimate
    mag_t           s4_n_next;
    logic [2*W-1:0] s4_prod;
    drive_t         s4_kind_reg;
    value_t         s4_value_reg;
    logic           s4_neg_reg;
    mag_t           s4_n_reg;
    mag_t           s4_q_reg;

    // stage 5: output register
    logic [REM_WIDTH-1:0] s5_rem;
    mag_t                 s5_q;
    value_t               s5_vel_value;
    value_t               out_value_next;
    drive_t               out_kind_reg;
    value_t               out_value_reg;

    // ------------------------------------------------------------------------
    // handshake and valid bits
    // ------------------------------------------------------------------------
    always_comb
    begin
        stage_ready[STAGES] = result.ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign valid_feed   = {valid_reg[STAGES-2:0], item.valid};
    assign item.ready   = stage_ready[0];
    assign state_update = valid_reg[2] && stage_ready[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_feed[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // configuration and state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_step_reg  <= SPEED_STEP_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
            angle_step_reg  <= ANGLE_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPEED_STEP:  speed_step_reg  <= cfg_data;
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MOTION_ABS;
            target_speed_reg    <= '0;
            remaining_delta_reg <= '0;
            target_angle_reg    <= '0;
        end
        else if (state_update)
        begin
            mode_reg            <= mode_next;
            target_speed_reg    <= target_speed_next;
            remaining_delta_reg <= remaining_delta_next;
            target_angle_reg    <= target_angle_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: magnitudes times reciprocals
    // ------------------------------------------------------------------------
    always_comb
    begin
        s1_ang_mag_next = abs_value(s0_ang_reg);
        s1_vel_mag_next = abs_value(s0_vel_reg);
        s1_prod_pi      = (2*W)'(s1_ang_mag_next) * (2*W)'(RECIP_PI);
        s1_prod_eps     = (2*W)'(s1_ang_mag_next) * (2*W)'(RECIP_PI_EPS);
        s1_prod_vel     = (2*W)'(s1_vel_mag_next) * (2*W)'(RECIP_FRAC_DEN);
    end

    // ------------------------------------------------------------------------
    // stage 2: remainder correction and x9.55
    // ------------------------------------------------------------------------
    always_comb
    begin
        // estimates are low by at most one, so one subtract settles them
        s2_rpi_raw = s1_ang_mag_reg - mag_t'(s1_qpi_reg * PI_MAG);
        s2_rpi     = (s2_rpi_raw >= PI_MAG) ? s2_rpi_raw - PI_MAG : s2_rpi_raw;
        s2_reps_raw = s1_ang_mag_reg - mag_t'(s1_qeps_reg * PI_EPS_MAG);
        s2_reps    = (s2_reps_raw >= PI_EPS_MAG) ? s2_reps_raw - PI_EPS_MAG : s2_reps_raw;

        s2_rvel_raw = s1_vel_mag_reg - mag_t'(s1_qvel_reg * FRAC_DEN_C);
        if (s2_rvel_raw >= FRAC_DEN_C)
        begin
            s2_qvel = s1_qvel_reg + mag_t'(1);
            s2_rvel = s2_rvel_raw - FRAC_DEN_C;
        end
        else
        begin
            s2_qvel = s1_qvel_reg;
            s2_rvel = s2_rvel_raw;
        end
        s2_lut_index = s2_rvel[LUT_INDEX_WIDTH-1:0];

        s2_rpm_mag = RPM_WIDTH'(s1_vel_mag_reg) * RPM_INT_C
                   + RPM_WIDTH'(s2_qvel) * RPM_FRAC_NUM_C
                   + RPM_WIDTH'(RPM_FRAC_LUT[s2_lut_index]);

        // truncating remainder keeps the sign of the dividend
        s2_mod_pi_next  = s1_ang_reg[W-1] ? -$signed(s2_rpi) : $signed(s2_rpi);
        s2_mod_eps_next = s1_ang_reg[W-1] ? -$signed(s2_reps) : $signed(s2_reps);
        s2_rpm_next     = s1_vel_neg_reg ? -$signed(s2_rpm_mag) : $signed(s2_rpm_mag);
    end

    // ------------------------------------------------------------------------
    // stage 3: commands, speed ramp and position step
    // ------------------------------------------------------------------------
    always_comb
    begin
        cmd_w   = widen(s2_cmd_reg);
        limit_w = widen_cfg(speed_limit_reg);
        rpm_w   = wide_t'(s2_rpm_reg);
        ts_w    = widen(target_speed_reg);
        sstep_w = widen_cfg(speed_step_reg);
        astep_w = widen_cfg(angle_step_reg);
        rem_w   = widen(remaining_delta_reg);
        pos     = (mode_reg == MOTION_ABS) ? s2_mod_eps_reg : s2_ang_reg;
        pos_w   = widen(pos);

        mode_next            = mode_reg;
        target_speed_next    = target_speed_reg;
        remaining_delta_next = remaining_delta_reg;
        target_angle_next    = target_angle_reg;
        s3_kind_next         = DRIVE_NONE;
        s3_value_next        = '0;
        s3_speed_next        = '0;

        case (s2_op_reg)
            OP_SET_SPEED:
            begin
                mode_next = MOTION_SPD;
                if (abs_wide(cmd_w) > limit_w)
                begin
                    target_speed_next = sat_value((cmd_w < 0) ? -limit_w : limit_w);
                end
                else
                begin
                    target_speed_next = s2_cmd_reg;
                end
            end
            OP_MOVE_ABS:
            begin
                mode_next            = MOTION_ABS;
                target_angle_next    = s2_cmd_reg;
                remaining_delta_next = sat_value(cmd_w - widen(s2_mod_pi_reg));
            end
            OP_MOVE_REL:
            begin
                mode_next            = MOTION_REL;
                remaining_delta_next = s2_cmd_reg;
                target_angle_next    = sat_value(widen(s2_ang_reg) + cmd_w);
            end
            OP_TICK:
            begin
                if (mode_reg == MOTION_SPD)
                begin
                    s3_kind_next = DRIVE_VELOCITY;
                    if (abs_wide(ts_w) < MIN_RPM_W)
                    begin
                        s3_speed_next = '0;
                    end
                    else if (((rpm_w < 0) == (ts_w < 0)) &&
                             (abs_wide(rpm_w - ts_w) < sstep_w))
                    begin
                        s3_speed_next = target_speed_reg;
                    end
                    else if (rpm_w < ts_w)
                    begin
                        s3_speed_next = sat_value(rpm_w + sstep_w);
                    end
                    else
                    begin
                        s3_speed_next = sat_value(rpm_w - sstep_w);
                    end
                end
                else if (abs_wide(widen(target_angle_reg) - pos_w) < astep_w)
                begin
                    // close enough: stop and forget the delta
                    remaining_delta_next = '0;
                end
                else
                begin
                    s3_kind_next = DRIVE_ANGLE;
                    if (remaining_delta_reg < 0)
                    begin
                        s3_value_next        = sat_value(pos_w - astep_w);
                        remaining_delta_next = sat_value(rem_w + astep_w);
                    end
                    else
                    begin
                        s3_value_next        = sat_value(pos_w + astep_w);
                        remaining_delta_next = sat_value(rem_w - astep_w);
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // stage 4 and 5: rpm / 9.55 as x20/191
    // ------------------------------------------------------------------------
    always_comb
    begin
        s4_n_next = abs_value(s3_speed_reg);
        s4_prod   = (2*W)'(s4_n_next) * (2*W)'(RECIP_SPEED);
    end

    always_comb
    begin
        s5_rem = REM_WIDTH'(s4_n_reg) * DIV_NUM_C - REM_WIDTH'(s4_q_reg) * DIV_DEN_C;
        s5_q   = (s5_rem >= DIV_DEN_C) ? s4_q_reg + mag_t'(1) : s4_q_reg;
        s5_vel_value   = s4_neg_reg ? -$signed(s5_q) : $signed(s5_q);
        out_value_next = (s4_kind_reg == DRIVE_VELOCITY) ? s5_vel_value : s4_value_reg;
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s0_op_reg  <= op_t'(item.operation);
            s0_cmd_reg <= item.command_value;
            s0_ang_reg <= item.measured_angle;
            s0_vel_reg <= item.measured_velocity;
        end
        if (stage_ready[1])
        begin
            s1_op_reg      <= s0_op_reg;
            s1_cmd_reg     <= s0_cmd_reg;
            s1_ang_reg     <= s0_ang_reg;
            s1_vel_neg_reg <= s0_vel_reg[W-1];
            s1_ang_mag_reg <= s1_ang_mag_next;
            s1_vel_mag_reg <= s1_vel_mag_next;
            s1_qpi_reg     <= s1_prod_pi[2*W-1:W];
            s1_qeps_reg    <= s1_prod_eps[2*W-1:W];
            s1_qvel_reg    <= s1_prod_vel[2*W-1:W];
        end
        if (stage_ready[2])
        begin
            s2_op_reg      <= s1_op_reg;
            s2_cmd_reg     <= s1_cmd_reg;
            s2_ang_reg     <= s1_ang_reg;
            s2_mod_pi_reg  <= s2_mod_pi_next;
            s2_mod_eps_reg <= s2_mod_eps_next;
            s2_rpm_reg     <= s2_rpm_next;
        end
        if (stage_ready[3])
        begin
            s3_kind_reg  <= s3_kind_next;
            s3_value_reg <= s3_value_next;
            s3_speed_reg <= s3_speed_next;
        end
        if (stage_ready[4])
        begin
            s4_kind_reg  <= s3_kind_reg;
            s4_value_reg <= s3_value_reg;
            s4_neg_reg   <= s3_speed_reg[W-1];
            s4_n_reg     <= s4_n_next;
            s4_q_reg     <= s4_prod[2*W-1:W];
        end
        if (stage_ready[5])
        begin
            out_kind_reg  <= s4_kind_reg;
            out_value_reg <= out_value_next;
        end
    end

    assign result.valid       = valid_reg[STAGES-1];
    assign result.drive_kind  = out_kind_reg;
    assign result.drive_value = out_value_reg;

endmodule
